[rtl/core/lru_block_buffer_cache_macros.svh]
// Assertion macros of the block buffer cache checker.
`ifndef LRU_BLOCK_BUFFER_CACHE_MACROS_SVH
`define LRU_BLOCK_BUFFER_CACHE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbc check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbc check failed");

`endif

[rtl/core/lbc_pkg.sv]
// Package: sizes, codes and shared types of the block buffer cache.
package lbc_pkg;

    localparam int SLOTS       = 16;
    localparam int DEVICE_BITS = 8;
    localparam int BLOCK_BITS  = 32;

    // Port field widths, fixed.
    localparam int OP_W         = 3;
    localparam int DEVICE_W     = 8;
    localparam int BLOCK_W      = 32;
    localparam int SLOT_FIELD_W = 4;
    localparam int STATUS_W     = 3;

    // Tag bits actually compared.
    localparam int DEV_W = (DEVICE_BITS < DEVICE_W) ? DEVICE_BITS : DEVICE_W;
    localparam int BLK_W = (BLOCK_BITS < BLOCK_W) ? BLOCK_BITS : BLOCK_W;
    localparam int TAG_W = DEV_W + BLK_W;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [SLOT_W-1:0] rank_t;
    typedef logic [TAG_W-1:0]  tag_t;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE     = 3'd0,
        OP_RELEASE     = 3'd1,
        OP_MARK_DIRTY  = 3'd2,
        OP_MARK_VALID  = 3'd3,
        OP_CLEAR_DIRTY = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT      = 3'd0,
        STAT_MISS     = 3'd1,
        STAT_BUSY     = 3'd2,
        STAT_NO_FREE  = 3'd3,
        STAT_NOT_BUSY = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_APPLY
    } seq_state_t;

    // One scanned entry presented to the compare unit.
    typedef struct packed {
        logic      clear;
        logic      sample;
        slot_idx_t idx;
        logic      match;
        logic      free;
        rank_t     rank;
    } scan_ctl_t;

    typedef struct packed {
        logic      hit_found;
        slot_idx_t hit_idx;
        logic      pick_found;
        slot_idx_t pick_idx;
    } scan_res_t;

    function automatic slot_idx_t to_idx(logic [SLOT_FIELD_W-1:0] s);
        to_idx = slot_idx_t'(s);
    endfunction

    function automatic logic [SLOT_FIELD_W-1:0] to_field(slot_idx_t i);
        to_field = SLOT_FIELD_W'(i);
    endfunction

endpackage

[rtl/core/lbc_if.sv]
// Request and response channel interfaces of the block buffer cache.
interface lbc_in_if;
    logic                              valid;
    logic                              ready;
    logic [lbc_pkg::OP_W-1:0]          operation;
    logic [lbc_pkg::DEVICE_W-1:0]      device;
    logic [lbc_pkg::BLOCK_W-1:0]       block_number;
    logic [lbc_pkg::SLOT_FIELD_W-1:0]  slot;

    modport source (output valid, operation, device, block_number, slot, input ready);
    modport sink   (input valid, operation, device, block_number, slot, output ready);
endinterface

interface lbc_out_if;
    logic                              valid;
    logic                              ready;
    logic [lbc_pkg::STATUS_W-1:0]      status;
    logic [lbc_pkg::SLOT_FIELD_W-1:0]  granted_slot;
    logic                              data_valid;

    modport source (output valid, status, granted_slot, data_valid, input ready);
    modport sink   (input valid, status, granted_slot, data_valid, output ready);
endinterface

[rtl/core/lru_block_buffer_cache.sv]
// Top level of the LRU block buffer cache tag and policy manager.
// Acquire: SCAN reads every slot's tag from the RAM at the sweep counter and judges each
//   registered read in the shared compare unit; APPLY then updates state and responds.
// Release and flag requests go from IDLE straight to APPLY. A request is taken only in
//   IDLE, one at a time; the next request is taken while a response still waits, and then stalls.
// Reset (async, rst_n low): all slots empty, idle, clean, invalid; ranks 0..SLOTS-1.
module lru_block_buffer_cache (
    input  logic            clk,
    input  logic            rst_n,
    lbc_in_if.sink          req,
    lbc_out_if.source       rsp
);

    // ------------------------------------------------------------------
    // Request capture and sequencer state
    // ------------------------------------------------------------------
    lbc_pkg::seq_state_t              state_reg, state_next;
    logic [lbc_pkg::OP_W-1:0]         op_reg,    op_next;
    logic [lbc_pkg::DEV_W-1:0]        dev_reg,   dev_next;
    logic [lbc_pkg::BLK_W-1:0]        blk_reg,   blk_next;
    logic [lbc_pkg::SLOT_FIELD_W-1:0] slot_reg,  slot_next;
    logic [lbc_pkg::CNT_W-1:0]        cnt_reg,   cnt_next;
    lbc_pkg::slot_idx_t               ptr_reg,   ptr_next;
    logic                             rd_vld_reg, rd_vld_next;

    // Per-slot flags live in flops; tags live in the RAM.
    logic [lbc_pkg::SLOTS-1:0] used_reg,  used_next;
    logic [lbc_pkg::SLOTS-1:0] busy_reg,  busy_next;
    logic [lbc_pkg::SLOTS-1:0] dirty_reg, dirty_next;
    logic [lbc_pkg::SLOTS-1:0] valid_reg, valid_next;

    // Response register
    logic                             out_valid_reg,  out_valid_next;
    logic [lbc_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [lbc_pkg::SLOT_FIELD_W-1:0] out_slot_reg,   out_slot_next;
    logic                             out_dv_reg,     out_dv_next;

    logic                  ram_we;
    lbc_pkg::tag_t         ram_rdata;
    lbc_pkg::tag_t         key;
    lbc_pkg::rank_t        rank_rd;
    logic                  promote;
    lbc_pkg::scan_ctl_t    scan_ctl;
    lbc_pkg::scan_res_t    scan_res;
    logic                  out_free;
    logic                  req_in_range;
    logic                  slot_in_range;
    lbc_pkg::slot_idx_t    s_idx;

    assign key           = {dev_reg, blk_reg};
    assign out_free      = !out_valid_reg || rsp.ready;
    assign req_in_range  = (32'(req.slot) < 32'(lbc_pkg::SLOTS));
    assign slot_in_range = (32'(slot_reg) < 32'(lbc_pkg::SLOTS));
    // For non-acquire requests ptr_reg holds the addressed slot.
    assign s_idx         = ptr_reg;

    // ------------------------------------------------------------------
    // Tag store: read at the sweep counter, written on a miss allocation
    // ------------------------------------------------------------------
    lbc_ram #(
        .WIDTH (lbc_pkg::TAG_W),
        .DEPTH (lbc_pkg::SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (scan_res.pick_idx),
        .wdata (key),
        .raddr (cnt_reg[lbc_pkg::SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    lbc_rank u_rank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (ptr_reg),
        .promote (promote),
        .rd_rank (rank_rd)
    );

    // Entry read last cycle is judged this cycle, at ptr_reg.
    always_comb
    begin
        scan_ctl.clear  = (state_reg == lbc_pkg::SEQ_IDLE);
        scan_ctl.sample = (state_reg == lbc_pkg::SEQ_SCAN) && rd_vld_reg;
        scan_ctl.idx    = ptr_reg;
        scan_ctl.match  = used_reg[ptr_reg] && (ram_rdata == key);
        scan_ctl.free   = !busy_reg[ptr_reg] && !dirty_reg[ptr_reg];
        scan_ctl.rank   = rank_rd;
    end

    lbc_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .res   (scan_res)
    );

    // ------------------------------------------------------------------
    // Sequencer: IDLE takes a request, SCAN sweeps tags for acquire,
    // APPLY updates state and loads the response register.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        dev_next        = dev_reg;
        blk_next        = blk_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        rd_vld_next     = 1'b0;
        used_next       = used_reg;
        busy_next       = busy_reg;
        dirty_next      = dirty_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_dv_next     = out_dv_reg;
        ram_we          = 1'b0;
        promote         = 1'b0;
        req.ready       = 1'b0;

        case (state_reg)
            lbc_pkg::SEQ_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next   = req.operation;
                    dev_next  = req.device[lbc_pkg::DEV_W-1:0];
                    blk_next  = req.block_number[lbc_pkg::BLK_W-1:0];
                    slot_next = req.slot;
                    cnt_next  = '0;
                    if (req.operation == lbc_pkg::OP_ACQUIRE)
                    begin
                        state_next = lbc_pkg::SEQ_SCAN;
                    end
                    else
                    begin
                        state_next = lbc_pkg::SEQ_APPLY;
                        ptr_next   = req_in_range ? lbc_pkg::to_idx(req.slot) : '0;
                    end
                end
            end

            lbc_pkg::SEQ_SCAN:
            begin
                if (cnt_reg < lbc_pkg::SLOTS_CNT)
                begin
                    cnt_next    = cnt_reg + 1'b1;
                    rd_vld_next = 1'b1;
                    ptr_next    = cnt_reg[lbc_pkg::SLOT_W-1:0];
                end
                else if (!rd_vld_reg)
                begin
                    state_next = lbc_pkg::SEQ_APPLY;
                end
            end

            lbc_pkg::SEQ_APPLY:
            begin
                if (out_free)
                begin
                    state_next     = lbc_pkg::SEQ_IDLE;
                    out_valid_next = 1'b1;
                    out_slot_next  = slot_reg;
                    out_status_next = lbc_pkg::STAT_HIT;
                    out_dv_next    = slot_in_range && valid_reg[s_idx];
                    case (op_reg)
                        lbc_pkg::OP_ACQUIRE:
                        begin
                            if (scan_res.hit_found)
                            begin
                                out_slot_next = lbc_pkg::to_field(scan_res.hit_idx);
                                out_dv_next   = valid_reg[scan_res.hit_idx];
                                if (busy_reg[scan_res.hit_idx])
                                begin
                                    out_status_next = lbc_pkg::STAT_BUSY;
                                end
                                else
                                begin
                                    busy_next[scan_res.hit_idx] = 1'b1;
                                end
                            end
                            else if (scan_res.pick_found)
                            begin
                                ram_we                        = 1'b1;
                                used_next[scan_res.pick_idx]  = 1'b1;
                                busy_next[scan_res.pick_idx]  = 1'b1;
                                dirty_next[scan_res.pick_idx] = 1'b0;
                                valid_next[scan_res.pick_idx] = 1'b0;
                                out_status_next = lbc_pkg::STAT_MISS;
                                out_slot_next   = lbc_pkg::to_field(scan_res.pick_idx);
                                out_dv_next     = 1'b0;
                            end
                            else
                            begin
                                out_status_next = lbc_pkg::STAT_NO_FREE;
                                out_slot_next   = '0;
                                out_dv_next     = 1'b0;
                            end
                        end

                        lbc_pkg::OP_RELEASE:
                        begin
                            if (!slot_in_range || !busy_reg[s_idx])
                            begin
                                out_status_next = lbc_pkg::STAT_NOT_BUSY;
                            end
                            else
                            begin
                                promote          = 1'b1;
                                busy_next[s_idx] = 1'b0;
                            end
                        end

                        lbc_pkg::OP_MARK_DIRTY:
                        begin
                            if (!slot_in_range || !busy_reg[s_idx])
                            begin
                                out_status_next = lbc_pkg::STAT_NOT_BUSY;
                            end
                            else
                            begin
                                dirty_next[s_idx] = 1'b1;
                            end
                        end

                        lbc_pkg::OP_MARK_VALID:
                        begin
                            if (!slot_in_range || !busy_reg[s_idx])
                            begin
                                out_status_next = lbc_pkg::STAT_NOT_BUSY;
                            end
                            else
                            begin
                                valid_next[s_idx] = 1'b1;
                                out_dv_next       = 1'b1;
                            end
                        end

                        lbc_pkg::OP_CLEAR_DIRTY:
                        begin
                            if (slot_in_range)
                            begin
                                dirty_next[s_idx] = 1'b0;
                            end
                        end

                        // unknown codes only echo the slot
                        default:
                        begin
                            out_status_next = lbc_pkg::STAT_HIT;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = lbc_pkg::SEQ_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lbc_pkg::SEQ_IDLE;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            used_reg      <= '0;
            busy_reg      <= '0;
            dirty_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            used_reg      <= used_next;
            busy_reg      <= busy_next;
            dirty_reg     <= dirty_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        dev_reg        <= dev_next;
        blk_reg        <= blk_next;
        slot_reg       <= slot_next;
        ptr_reg        <= ptr_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_dv_reg     <= out_dv_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.granted_slot = out_slot_reg;
    assign rsp.data_valid   = out_dv_reg;

endmodule

[rtl/core/lbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/lbc_rank.sv]
// Recency ranks of all slots: one read port, promote-to-most-recent update.
module lbc_rank (
    input  logic              clk,
    input  logic              rst_n,
    input  lbc_pkg::slot_idx_t rd_idx,
    input  logic              promote,
    output lbc_pkg::rank_t    rd_rank
);

    lbc_pkg::rank_t rank_reg  [lbc_pkg::SLOTS];
    lbc_pkg::rank_t rank_next [lbc_pkg::SLOTS];

    assign rd_rank = rank_reg[rd_idx];

    // Everyone above the promoted slot moves down one; the slot goes to the top.
    always_comb
    begin
        for (int i = 0; i < lbc_pkg::SLOTS; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (promote && (rank_reg[i] > rd_rank))
            begin
                rank_next[i] = rank_reg[i] - 1'b1;
            end
        end
        if (promote)
        begin
            rank_next[rd_idx] = lbc_pkg::rank_t'(lbc_pkg::SLOTS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lbc_pkg::SLOTS; i++)
            begin
                rank_reg[i] <= lbc_pkg::rank_t'(i);
            end
        end
        else
        begin
            for (int i = 0; i < lbc_pkg::SLOTS; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

endmodule

[rtl/core/lbc_scan.sv]
// Shared compare unit: keeps the most recent tag hit and least recent free slot.
module lbc_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  lbc_pkg::scan_ctl_t ctl,
    output lbc_pkg::scan_res_t res
);

    logic               hit_found_reg,  hit_found_next;
    lbc_pkg::slot_idx_t hit_idx_reg,    hit_idx_next;
    lbc_pkg::rank_t     hit_rank_reg,   hit_rank_next;
    logic               pick_found_reg, pick_found_next;
    lbc_pkg::slot_idx_t pick_idx_reg,   pick_idx_next;
    lbc_pkg::rank_t     pick_rank_reg,  pick_rank_next;

    always_comb
    begin
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        pick_found_next = pick_found_reg;
        pick_idx_next   = pick_idx_reg;
        pick_rank_next  = pick_rank_reg;
        if (ctl.clear)
        begin
            hit_found_next  = 1'b0;
            pick_found_next = 1'b0;
        end
        else if (ctl.sample)
        begin
            if (ctl.match && (!hit_found_reg || (ctl.rank > hit_rank_reg)))
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = ctl.idx;
                hit_rank_next  = ctl.rank;
            end
            if (ctl.free && (!pick_found_reg || (ctl.rank < pick_rank_reg)))
            begin
                pick_found_next = 1'b1;
                pick_idx_next   = ctl.idx;
                pick_rank_next  = ctl.rank;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            pick_found_reg <= 1'b0;
        end
        else
        begin
            hit_found_reg  <= hit_found_next;
            pick_found_reg <= pick_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        hit_rank_reg  <= hit_rank_next;
        pick_idx_reg  <= pick_idx_next;
        pick_rank_reg <= pick_rank_next;
    end

    assign res.hit_found  = hit_found_reg;
    assign res.hit_idx    = hit_idx_reg;
    assign res.pick_found = pick_found_reg;
    assign res.pick_idx   = pick_idx_reg;

endmodule

[rtl/core/lbc_checker.sv]
// Port-level checker for the block buffer cache, bound to the top level.
`include "lru_block_buffer_cache_macros.svh"

module lbc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [lbc_pkg::STATUS_W-1:0]     status,
    input logic [lbc_pkg::SLOT_FIELD_W-1:0] granted_slot,
    input logic                             data_valid
);

    // a stalled response holds
    `LBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(granted_slot) && $stable(data_valid))

    // one request at a time: never ready right after an accept
    `LBC_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // no free slot reports slot 0 with no data
    `LBC_ASSERT_NOW(a_no_free_zero, rsp_valid && (status == lbc_pkg::STAT_NO_FREE), (granted_slot == '0) && !data_valid)

    // a fresh allocation never holds valid data
    `LBC_ASSERT_NOW(a_miss_invalid, rsp_valid && (status == lbc_pkg::STAT_MISS), !data_valid)

endmodule

bind lru_block_buffer_cache lbc_checker u_lbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .granted_slot (rsp.granted_slot),
    .data_valid   (rsp.data_valid)
);

[dv/lru_block_buffer_cache_test.sv]
// Self-checking testbench for the LRU block buffer cache tag and policy manager.
module lru_block_buffer_cache_test;

    import lbc_pkg::*;

    // Reserved operation codes: the block echoes the slot and changes nothing.
    localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;   // counted requests per phase, reserved ops excluded
    localparam int LONG_HOLD   = 300;   // receiver hold-off that backs the block up
    localparam int SETTLE      = SLOTS + 6;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic [DEVICE_W-1:0]     device;
        logic [BLOCK_W-1:0]      block_number;
        logic [SLOT_FIELD_W-1:0] slot;
    } cache_req_t;

    typedef struct {
        status_t                 status;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    data_valid;
    } cache_rsp_t;

    // Request mixes: fill drives the cache into no-free-slot, drain frees it again.
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} load_mix_t;
    typedef enum int {PICK_USED, PICK_BUSY, PICK_DIRTY} slot_pick_t;

    logic clk;
    logic rst_n;

    lbc_in_if  req_ch ();
    lbc_out_if rsp_ch ();

    lru_block_buffer_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Cache model: tags, flags and recency ranks (rank 0 = least recent).
    // ------------------------------------------------------------------
    bit                  m_used  [SLOTS];
    logic [DEVICE_W-1:0] m_dev   [SLOTS];
    logic [BLOCK_W-1:0]  m_blk   [SLOTS];
    bit                  m_busy  [SLOTS];
    bit                  m_dirty [SLOTS];
    bit                  m_valid [SLOTS];
    int                  m_rank  [SLOTS];

    cache_req_t pending_reqs [$];   // stimulus not yet offered to the block
    cache_rsp_t awaited_rsps [$];   // predicted responses, oldest first

    bit failed;
    bit req_taken;                  // request accepted at the last rising edge
    bit idle_in;
    bit idle_out;
    int send_gap;
    int stall_left;
    int rsp_hold_req;               // long hold-off handed to the receiver

    function automatic void clear_cache_model();
        for (int i = 0; i < SLOTS; i++)
        begin
            m_used[i]  = 0;
            m_dev[i]   = '0;
            m_blk[i]   = '0;
            m_busy[i]  = 0;
            m_dirty[i] = 0;
            m_valid[i] = 0;
            m_rank[i]  = i;
        end
    endfunction

    function automatic cache_rsp_t make_rsp(status_t st, logic [SLOT_FIELD_W-1:0] s, logic v);
        cache_rsp_t r;
        r.status     = st;
        r.slot       = s;
        r.data_valid = v;
        return r;
    endfunction

    // Applies one request to the model and returns the response it must produce.
    function automatic cache_rsp_t apply_request(cache_req_t r);
        int hit;
        int pick;
        int s;
        int old_rank;
        bit inr;
        inr = r.slot < SLOTS;
        s   = inr ? int'(r.slot) : 0;
        case (r.op)
            OP_ACQUIRE:
            begin
                hit  = -1;
                pick = -1;
                // tag lookup, most recent match wins
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (m_used[i] && m_dev[i][DEV_W-1:0] == r.device[DEV_W-1:0]
                            && m_blk[i][BLK_W-1:0] == r.block_number[BLK_W-1:0])
                    begin
                        if (hit < 0 || m_rank[i] > m_rank[hit])
                            hit = i;
                    end
                end
                if (hit >= 0)
                begin
                    if (m_busy[hit])
                        return make_rsp(STAT_BUSY, SLOT_FIELD_W'(hit), m_valid[hit]);
                    m_busy[hit] = 1;
                    return make_rsp(STAT_HIT, SLOT_FIELD_W'(hit), m_valid[hit]);
                end
                // miss: least recent slot that is neither busy nor dirty
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!m_busy[i] && !m_dirty[i])
                    begin
                        if (pick < 0 || m_rank[i] < m_rank[pick])
                            pick = i;
                    end
                end
                if (pick < 0)
                    return make_rsp(STAT_NO_FREE, '0, 1'b0);
                m_used[pick]  = 1;
                m_dev[pick]   = r.device;
                m_blk[pick]   = r.block_number;
                m_busy[pick]  = 1;
                m_dirty[pick] = 0;
                m_valid[pick] = 0;
                return make_rsp(STAT_MISS, SLOT_FIELD_W'(pick), 1'b0);
            end
            OP_RELEASE:
            begin
                if (!inr || !m_busy[s])
                    return make_rsp(STAT_NOT_BUSY, r.slot, inr ? m_valid[s] : 1'b0);
                old_rank = m_rank[s];
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (m_rank[i] > old_rank)
                        m_rank[i]--;
                end
                m_rank[s] = SLOTS - 1;
                m_busy[s] = 0;
                return make_rsp(STAT_HIT, r.slot, m_valid[s]);
            end
            OP_MARK_DIRTY:
            begin
                if (!inr || !m_busy[s])
                    return make_rsp(STAT_NOT_BUSY, r.slot, inr ? m_valid[s] : 1'b0);
                m_dirty[s] = 1;
                return make_rsp(STAT_HIT, r.slot, m_valid[s]);
            end
            OP_MARK_VALID:
            begin
                if (!inr || !m_busy[s])
                    return make_rsp(STAT_NOT_BUSY, r.slot, inr ? m_valid[s] : 1'b0);
                m_valid[s] = 1;
                return make_rsp(STAT_HIT, r.slot, 1'b1);
            end
            OP_CLEAR_DIRTY:
            begin
                if (!inr)
                    return make_rsp(STAT_HIT, r.slot, 1'b0);
                m_dirty[s] = 0;
                return make_rsp(STAT_HIT, r.slot, m_valid[s]);
            end
            default:
                return make_rsp(STAT_HIT, r.slot, inr ? m_valid[s] : 1'b0);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic void post_request(logic [OP_W-1:0] op, logic [DEVICE_W-1:0] dev,
                                         logic [BLOCK_W-1:0] blk,
                                         logic [SLOT_FIELD_W-1:0] s);
        cache_req_t r;
        r.op           = op;
        r.device       = dev;
        r.block_number = blk;
        r.slot         = s;
        pending_reqs.push_back(r);
    endfunction

    function automatic int random_slot_with(slot_pick_t which);
        int cands [$];
        for (int i = 0; i < SLOTS; i++)
        begin
            if ((which == PICK_USED && m_used[i]) || (which == PICK_BUSY && m_busy[i])
                    || (which == PICK_DIRTY && m_dirty[i]))
                cands.push_back(i);
        end
        if (cands.size() == 0)
            return -1;
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    // Mostly well-formed traffic: acquires on resident tags or a small tag pool, flag and
    // release requests aimed at busy slots (clear dirty at dirty ones); the rest is random noise.
    function automatic void make_random_req(load_mix_t mix, output cache_req_t r);
        int roll;
        int pick;
        int t;
        int c_acq;
        int c_rel;
        int c_dirty;
        int c_valid;
        int c_clear;
        case (mix)
            MIX_FILL:  begin c_acq = 55; c_rel = 65; c_dirty = 75; c_valid = 88; c_clear = 94; end
            MIX_DRAIN: begin c_acq = 25; c_rel = 65; c_dirty = 70; c_valid = 80; c_clear = 94; end
            default:   begin c_acq = 40; c_rel = 62; c_dirty = 72; c_valid = 84; c_clear = 94; end
        endcase
        r.device       = DEVICE_W'($urandom);
        r.block_number = $urandom;
        r.slot         = SLOT_FIELD_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < c_acq)
        begin
            r.op = OP_ACQUIRE;
            roll = $urandom_range(0, 99);
            pick = random_slot_with(PICK_USED);
            if (roll < 50 && pick >= 0)
            begin
                r.device       = m_dev[pick];
                r.block_number = m_blk[pick];
            end
            else if (roll < 88)
            begin
                // small tag pool, larger than the cache so misses evict
                t = $urandom_range(0, 23);
                r.device       = (t % 4 == 3) ? '1 : DEVICE_W'(t % 4);
                r.block_number = (t % 8 == 7) ? ~BLOCK_W'(t) : BLOCK_W'(t);
            end
        end
        else if (roll < c_clear)
        begin
            if (roll < c_rel)
                r.op = OP_RELEASE;
            else if (roll < c_dirty)
                r.op = OP_MARK_DIRTY;
            else if (roll < c_valid)
                r.op = OP_MARK_VALID;
            else
                r.op = OP_CLEAR_DIRTY;
            pick = random_slot_with(r.op == OP_CLEAR_DIRTY ? PICK_DIRTY : PICK_BUSY);
            if ($urandom_range(0, 99) < 75 && pick >= 0)
                r.slot = SLOT_FIELD_W'(pick);
        end
        else
            r.op = OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
    endfunction

    // Holds the stimulus until every predicted response is back, then lets
    // the block settle.
    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || req_ch.valid || awaited_rsps.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: changes inputs on the falling edge, holds a request
    // until the rising edge that accepts it, then maybe leaves a gap.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        cache_req_t nx;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (req_taken || !req_ch.valid)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                nx = pending_reqs.pop_front();
                req_ch.operation    <= nx.op;
                req_ch.device       <= nx.device;
                req_ch.block_number <= nx.block_number;
                req_ch.slot         <= nx.slot;
                req_ch.valid        <= 1'b1;
                send_gap = (idle_in && $urandom_range(0, 99) < 35) ? draw_gap() : 0;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Response receiver: random stalls, plus the long hold-off on demand.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_hold_req > 0)
            begin
                stall_left   = rsp_hold_req;
                rsp_hold_req = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_out && $urandom_range(0, 99) < 25)
            begin
                stall_left = draw_gap() - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks responses against the oldest prediction, then
    // predicts for the request accepted at this edge. The response check
    // comes first so that a response never meets its own request's entry.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cache_req_t got;
        cache_rsp_t want;
        if (!rst_n)
            req_taken = 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_rsps.size() == 0)
                begin
                    $error("response with none awaited: status %0d slot %0d",
                           rsp_ch.status, rsp_ch.granted_slot);
                    failed = 1'b1;
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                        failed = 1'b1;
                    end
                    if (rsp_ch.granted_slot !== want.slot)
                    begin
                        $error("granted_slot: expected %0d, actual %0d",
                               want.slot, rsp_ch.granted_slot);
                        failed = 1'b1;
                    end
                    if (rsp_ch.data_valid !== want.data_valid)
                    begin
                        $error("data_valid: expected %0d, actual %0d",
                               want.data_valid, rsp_ch.data_valid);
                        failed = 1'b1;
                    end
                end
            end
            req_taken = req_ch.valid && req_ch.ready;
            if (req_taken)
            begin
                got.op           = req_ch.operation;
                got.device       = req_ch.device;
                got.block_number = req_ch.block_number;
                got.slot         = req_ch.slot;
                awaited_rsps.push_back(apply_request(got));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: directed requests, then phases of random traffic.
    // ------------------------------------------------------------------
    initial
    begin
        cache_req_t r;
        int counted;
        load_mix_t mix;
        failed       = 1'b0;
        req_taken    = 1'b0;
        send_gap     = 0;
        stall_left   = 0;
        rsp_hold_req = 0;
        idle_in      = 1'b0;
        idle_out     = 1'b0;
        clear_cache_model();
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_ACQUIRE;
        req_ch.device       = '0;
        req_ch.block_number = '0;
        req_ch.slot         = '0;
        rsp_ch.ready        = 1'b0;
        rst_n               = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // flag and release requests on idle slots, clear dirty, reserved ops
        post_request(OP_RELEASE,     8'h00, 32'h0, 4'd0);
        post_request(OP_MARK_DIRTY,  8'hFF, 32'hFFFF_FFFF, 4'd15);
        post_request(OP_MARK_VALID,  8'h00, 32'h0, 4'd3);
        post_request(OP_CLEAR_DIRTY, 8'h00, 32'h0, 4'd7);
        post_request(OP_RESERVED_FIRST,      8'h12, 32'h3456_789A, 4'd9);
        post_request(OP_W'(OP_RESERVED_FIRST + 1), 8'h00, 32'h0, 4'd15);
        post_request(OP_RESERVED_LAST,       8'hFF, 32'hFFFF_FFFF, 4'd0);
        // misses at the tag extremes, then a busy hit on the first
        post_request(OP_ACQUIRE,     8'h00, 32'h0, 4'd0);
        post_request(OP_ACQUIRE,     8'hFF, 32'hFFFF_FFFF, 4'd15);
        post_request(OP_ACQUIRE,     8'h00, 32'h0, 4'd5);
        // fill, dirty and release slot 0, then hit it while idle
        post_request(OP_MARK_VALID,  8'h00, 32'h0, 4'd0);
        post_request(OP_MARK_DIRTY,  8'h00, 32'h0, 4'd0);
        post_request(OP_RELEASE,     8'h00, 32'h0, 4'd0);
        post_request(OP_ACQUIRE,     8'h00, 32'h0, 4'd0);
        post_request(OP_RESERVED_LAST, 8'h00, 32'h0, 4'd0);
        post_request(OP_CLEAR_DIRTY, 8'h00, 32'h0, 4'd0);
        post_request(OP_RELEASE,     8'h00, 32'h0, 4'd0);
        post_request(OP_RELEASE,     8'h00, 32'h0, 4'd1);
        // fresh tags go to the least recent clean slot
        post_request(OP_ACQUIRE,     8'hA5, 32'h5A5A_5A5A, 4'd0);
        post_request(OP_ACQUIRE,     8'h5A, 32'hA5A5_A5A5, 4'd0);
        wait_quiet();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // phase 0: fill with a steady sender against a long receiver
            // hold-off, so the block backs up and stalls its input
            if (ph == 0)
            begin
                mix          = MIX_FILL;
                idle_in      = 1'b0;
                idle_out     = 1'b0;
                rsp_hold_req = LONG_HOLD;
            end
            else
            begin
                mix      = load_mix_t'($urandom_range(0, 2));
                idle_in  = $urandom_range(0, 3) != 0;
                idle_out = $urandom_range(0, 3) != 0;
                if ($urandom_range(0, 3) == 0)
                    rsp_hold_req = LONG_HOLD;
            end
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                while (pending_reqs.size() >= 2)
                    @(negedge clk);
                make_random_req(mix, r);
                if (r.op <= OP_CLEAR_DIRTY)
                    counted++;
                pending_reqs.push_back(r);
            end
            // sender pauses here until all responses are back
            wait_quiet();
        end

        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lbc_pkg.sv
rtl/core/lbc_if.sv
rtl/core/lbc_ram.sv
rtl/core/lbc_rank.sv
rtl/core/lbc_scan.sv
rtl/core/lru_block_buffer_cache.sv
rtl/core/lbc_checker.sv
dv/lru_block_buffer_cache_test.sv
